// ===== design/biou_pkg.sv =====
//------------------------------------------------------------------------------
// biou_pkg
// Shared types for the box intersection-over-union pipeline.
//------------------------------------------------------------------------------
`default_nettype none

package biou_pkg;

   // Special-case flags that travel beside the divider data
   typedef struct packed {
      logic invalid;   // union area zero or negative
      logic sat;       // intersection at or above union
   } biou_flag_type;

endpackage : biou_pkg

`default_nettype wire

// ===== design/biou_div.sv =====
//------------------------------------------------------------------------------
// biou_div
// Pipelined restoring fraction divider: one quotient bit per stage, then a
// round-to-nearest (ties up) stage that also applies saturation and the
// invalid-union override.
//------------------------------------------------------------------------------
`default_nettype none

module biou_div #(
   parameter int NUM_BITS  = 36,
   parameter int FRAC_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire  [NUM_BITS-1:0]         in_num,
   input  wire  [NUM_BITS-1:0]         in_den,
   input  biou_pkg::biou_flag_type     in_flags,
   output logic                        out_valid,
   input  wire                         out_ready,
   output logic [FRAC_BITS:0]          out_ratio,
   output logic                        out_invalid
);
   import biou_pkg::*;

   localparam int NS = FRAC_BITS + 1;   // step stages plus rounding stage
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // per-stage registers
   logic [NUM_BITS-1:0]  r_ff   [FRAC_BITS];
   logic [NUM_BITS-1:0]  den_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff   [FRAC_BITS];
   biou_flag_type        flag_ff[FRAC_BITS];
   logic [NS-1:0]        v_ff;
   logic [FRAC_BITS:0]   ratio_ff;
   logic                 inv_ff;

   // stage sources
   logic [NUM_BITS-1:0]  r_src   [FRAC_BITS];
   logic [NUM_BITS-1:0]  den_src [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_src   [FRAC_BITS];
   biou_flag_type        flag_src[FRAC_BITS];
   logic [NS-1:0]        v_src;

   // a stage moves when it is empty or the next one moves
   logic [NS:0] mv;
   assign mv[NS] = out_ready;

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_mv
         assign mv[k] = !v_ff[k] || mv[k+1];
      end
   endgenerate

   assign in_ready = mv[0];

   // stage sources: stage zero from the port, others from the stage before
   assign r_src[0]    = (in_flags.invalid || in_flags.sat) ? '0 : in_num;
   assign den_src[0]  = in_den;
   assign q_src[0]    = '0;
   assign flag_src[0] = in_flags;
   assign v_src[0]    = in_valid;

   generate
      for (k = 1; k < FRAC_BITS; k++) begin : g_src
         assign r_src[k]    = r_ff[k-1];
         assign den_src[k]  = den_ff[k-1];
         assign q_src[k]    = q_ff[k-1];
         assign flag_src[k] = flag_ff[k-1];
         assign v_src[k]    = v_ff[k-1];
      end
   endgenerate
   assign v_src[FRAC_BITS] = v_ff[FRAC_BITS-1];

   // one restoring step per stage
   generate
      for (k = 0; k < FRAC_BITS; k++) begin : g_step
         logic [NUM_BITS:0] r2;
         logic              take;
         logic [NUM_BITS:0] diff;

         always_comb begin
            r2   = {r_src[k], 1'b0};
            take = (r2 >= {1'b0, den_src[k]});
            diff = r2 - {1'b0, den_src[k]};
         end

         always_ff @(posedge clock) begin
            if (mv[k]) begin
               r_ff[k]    <= take ? diff[NUM_BITS-1:0] : r2[NUM_BITS-1:0];
               den_ff[k]  <= den_src[k];
               q_ff[k]    <= {q_src[k][FRAC_BITS-2:0], take};
               flag_ff[k] <= flag_src[k];
            end
         end
      end
   endgenerate

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (mv[i]) begin
               v_ff[i] <= v_src[i];
            end
         end
      end
   end

   // rounding, saturation and invalid override
   logic               rnd;
   logic [FRAC_BITS:0] ratio_in;
   logic               inv_in;

   always_comb begin
      rnd = ({r_ff[FRAC_BITS-1], 1'b0} >= {1'b0, den_ff[FRAC_BITS-1]});
      ratio_in = {1'b0, q_ff[FRAC_BITS-1]} + (FRAC_BITS+1)'(rnd);
      inv_in   = flag_ff[FRAC_BITS-1].invalid;
      if (flag_ff[FRAC_BITS-1].invalid) begin
         ratio_in = '0;
      end else if (flag_ff[FRAC_BITS-1].sat || ratio_in > ONE) begin
         ratio_in = ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (mv[FRAC_BITS]) begin
         ratio_ff <= ratio_in;
         inv_ff   <= inv_in;
      end
   end

   assign out_valid   = v_ff[FRAC_BITS];
   assign out_ratio   = ratio_ff;
   assign out_invalid = inv_ff;

endmodule : biou_div

`default_nettype wire

// ===== design/box_iou_unit.sv =====
//------------------------------------------------------------------------------
// box_iou_unit
// Intersection over union of two axis-aligned boxes, fully pipelined.
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------
//  req_    | in  | tdata: a_left, a_top, a_right, a_bottom,
//          |     |        b_left, b_top, b_right, b_bottom (COORD_BITS each)
//  rsp_    | out | tdata: overlap_ratio (RATIO_FRAC_BITS+1, zero padded)
//          |     | tuser: union_invalid
//
// One item per cycle sustained while rsp_tready stays high. The divider
// resolves one quotient bit per pipeline stage.
// Reset clears only the valid bits; no clearing pass is needed.
// A full stage holds while the one after it is full and stalled, so empty
// stages still fill while a finished result waits on rsp_tready.
//------------------------------------------------------------------------------
`default_nettype none

module box_iou_unit #(
   parameter int COORD_BITS      = 16,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
   input  wire  [8*COORD_BITS-1:0]                  req_tdata,
   input  wire                                      req_tvalid,
   output logic                                     req_tready,
   // overlap_ratio, then zero padding
   output logic [((RATIO_FRAC_BITS+8)/8)*8-1:0]     rsp_tdata,
   // union_invalid
   output logic                                     rsp_tuser,
   output logic                                     rsp_tvalid,
   input  wire                                      rsp_tready
);
   import biou_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int DW    = C + 1;          // coordinate difference
   localparam int PW    = 2 * DW;         // area product
   localparam int UW    = PW + 2;         // union sum
   localparam int RW    = RATIO_FRAC_BITS + 1;
   localparam int RSP_W = ((RATIO_FRAC_BITS + 8) / 8) * 8;
   localparam logic [RW-1:0] ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

   // unpack the request
   logic signed [C-1:0] al, at, ar, ab, bl, bt, br, bb;
   assign al = req_tdata[0*C +: C];
   assign at = req_tdata[1*C +: C];
   assign ar = req_tdata[2*C +: C];
   assign ab = req_tdata[3*C +: C];
   assign bl = req_tdata[4*C +: C];
   assign bt = req_tdata[5*C +: C];
   assign br = req_tdata[6*C +: C];
   assign bb = req_tdata[7*C +: C];

   // stage valid bits and move chain
   logic [3:0] v_ff;
   logic [4:0] mv;
   logic       div_ready;

   assign mv[4] = div_ready;
   assign mv[3] = !v_ff[3] || mv[4];
   assign mv[2] = !v_ff[2] || mv[3];
   assign mv[1] = !v_ff[1] || mv[2];
   assign mv[0] = !v_ff[0] || mv[1];
   assign req_tready = mv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (mv[0]) v_ff[0] <= req_tvalid;
         if (mv[1]) v_ff[1] <= v_ff[0];
         if (mv[2]) v_ff[2] <= v_ff[1];
         if (mv[3]) v_ff[3] <= v_ff[2];
      end
   end

   // stage 1: box sides and per-axis overlaps
   logic signed [DW-1:0] aw_in, ah_in, bw_in, bh_in, ow_in, oh_in;
   logic signed [DW-1:0] aw_ff, ah_ff, bw_ff, bh_ff, ow_ff, oh_ff;
   logic signed [C-1:0]  min_r, max_l, min_b, max_t;

   always_comb begin
      min_r = (ar < br) ? ar : br;
      max_l = (al > bl) ? al : bl;
      min_b = (ab < bb) ? ab : bb;
      max_t = (at > bt) ? at : bt;
      aw_in = DW'(ar) - DW'(al);
      ah_in = DW'(ab) - DW'(at);
      bw_in = DW'(br) - DW'(bl);
      bh_in = DW'(bb) - DW'(bt);
      ow_in = DW'(min_r) - DW'(max_l);
      oh_in = DW'(min_b) - DW'(max_t);
   end

   always_ff @(posedge clock) begin
      if (mv[0]) begin
         aw_ff <= aw_in;
         ah_ff <= ah_in;
         bw_ff <= bw_in;
         bh_ff <= bh_in;
         ow_ff <= ow_in;
         oh_ff <= oh_in;
      end
   end

   // stage 2: areas and intersection
   logic signed [PW-1:0] area_a_in, area_b_in, inter_in;
   logic signed [PW-1:0] area_a_ff, area_b_ff, inter_ff;

   always_comb begin
      area_a_in = aw_ff * ah_ff;
      area_b_in = bw_ff * bh_ff;
      inter_in  = (ow_ff < 0 || oh_ff < 0) ? '0 : ow_ff * oh_ff;
   end

   always_ff @(posedge clock) begin
      if (mv[1]) begin
         area_a_ff <= area_a_in;
         area_b_ff <= area_b_in;
         inter_ff  <= inter_in;
      end
   end

   // stage 3: union
   logic signed [UW-1:0] uni_in, uni_ff, inter3_ff;

   assign uni_in = UW'(area_a_ff) + UW'(area_b_ff) - UW'(inter_ff);

   always_ff @(posedge clock) begin
      if (mv[2]) begin
         uni_ff    <= uni_in;
         inter3_ff <= UW'(inter_ff);
      end
   end

   // stage 4: special cases
   biou_flag_type        flag_in, flag_ff;
   logic [UW-1:0]        num_ff, den_ff;

   always_comb begin
      flag_in.invalid = uni_ff[UW-1] || (uni_ff == '0);
      flag_in.sat     = !flag_in.invalid && (inter3_ff >= uni_ff);
   end

   always_ff @(posedge clock) begin
      if (mv[3]) begin
         flag_ff <= flag_in;
         num_ff  <= inter3_ff;
         den_ff  <= uni_ff;
      end
   end

   // fraction divider and output register
   logic [RW-1:0] ratio;

   biou_div #(
      .NUM_BITS  (UW),
      .FRAC_BITS (RATIO_FRAC_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v_ff[3]),
      .in_ready    (div_ready),
      .in_num      (num_ff),
      .in_den      (den_ff),
      .in_flags    (flag_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_ratio   (ratio),
      .out_invalid (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'(ratio);

   // checks
   a_ratio_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ratio <= ONE)
      else $error("ratio above one");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> ratio == '0)
      else $error("invalid union with nonzero ratio");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule : box_iou_unit

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb
// Testbench for box_iou_unit. Box pairs go in on req_, and every accepted pair
// is run through a local intersection-over-union predictor. Each result on
// rsp_ is checked in order against the oldest prediction. Both sides idle and
// stall at random, and the output side holds off once long enough to back up
// the pipeline.
//------------------------------------------------------------------------------
module tb;

   localparam int COORD_BITS      = 16;
   localparam int RATIO_FRAC_BITS = 16;
   localparam int REQ_W           = 8*COORD_BITS;
   localparam int RSP_W           = ((RATIO_FRAC_BITS+8)/8)*8;
   localparam longint RATIO_ONE   = 64'd1 << RATIO_FRAC_BITS;
   localparam int PIPE_LATENCY    = 4 + RATIO_FRAC_BITS + 1;
   localparam int RANDOM_PAIRS    = 1250;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int HOLD_AFTER      = 350;   // accepted items before the long hold
   localparam int HOLD_CYCLES     = 150;
   localparam int MAX_PRINTED     = 40;
   localparam int SB_DEPTH        = 64;    // well above the items in flight

   // Expected result of one box pair
   typedef struct packed {
      logic [RATIO_FRAC_BITS:0] ratio;
      logic                     invalid;
   } iou_answer_type;

   //---------------------------------------------------------------------------
   // Scoreboard: predicts IoU for accepted pairs, checks results in order
   //---------------------------------------------------------------------------
   class iou_checker_type;
      iou_answer_type expected_iou[SB_DEPTH];
      int             sb_head        = 0;
      int             sb_tail        = 0;
      int             pending        = 0;
      int             fail_count     = 0;
      int             accepted_count = 0;
      int             result_count   = 0;

      function iou_answer_type predict_iou(logic [REQ_W-1:0] pair);
         longint         c[8];
         longint         w, h, inter, area_a, area_b, uni, rem, quo;
         iou_answer_type ans;
         for (int i = 0; i < 8; i++)
            c[i] = longint'($signed(pair[COORD_BITS*i +: COORD_BITS]));
         // per-axis overlap: smaller max minus larger min (c: al,at,ar,ab,bl,bt,br,bb)
         w = ((c[2] < c[6]) ? c[2] : c[6]) - ((c[0] > c[4]) ? c[0] : c[4]);
         h = ((c[3] < c[7]) ? c[3] : c[7]) - ((c[1] > c[5]) ? c[1] : c[5]);
         inter  = (w < 0 || h < 0) ? 0 : w * h;
         area_a = (c[3] - c[1]) * (c[2] - c[0]);
         area_b = (c[7] - c[5]) * (c[6] - c[4]);
         uni    = area_a + area_b - inter;
         ans.invalid = 1'b0;
         if (uni <= 0) begin
            ans.ratio   = '0;
            ans.invalid = 1'b1;
         end else if (inter >= uni) begin
            ans.ratio = RATIO_ONE[RATIO_FRAC_BITS:0];
         end else begin
            // one quotient bit per step, then round half up
            rem = inter;
            quo = 0;
            for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
               rem = rem << 1;
               quo = quo << 1;
               if (rem >= uni) begin
                  rem = rem - uni;
                  quo = quo | 1;
               end
            end
            if ((rem << 1) >= uni)
               quo = quo + 1;
            if (quo > RATIO_ONE)
               quo = RATIO_ONE;
            ans.ratio = quo[RATIO_FRAC_BITS:0];
         end
         return ans;
      endfunction

      task report_mismatch(string what, longint got, longint want);
         if (fail_count < MAX_PRINTED)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_count, what, got, want);
         fail_count++;
      endtask

      task note_request(logic [REQ_W-1:0] pair);
         if (pending >= SB_DEPTH) begin
            report_mismatch("scoreboard overflow, items in flight", pending, SB_DEPTH);
         end else begin
            expected_iou[sb_tail] = predict_iou(pair);
            sb_tail = (sb_tail + 1) % SB_DEPTH;
            pending++;
         end
         accepted_count++;
      endtask

      task check_result(logic [RSP_W-1:0] data, logic invalid_bit);
         iou_answer_type want;
         if (pending == 0) begin
            report_mismatch("unexpected result, ratio", data[RATIO_FRAC_BITS:0], 0);
         end else begin
            want = expected_iou[sb_head];
            sb_head = (sb_head + 1) % SB_DEPTH;
            pending--;
            if (data[RATIO_FRAC_BITS:0] !== want.ratio)
               report_mismatch("overlap_ratio", data[RATIO_FRAC_BITS:0], want.ratio);
            if (data[RSP_W-1:RATIO_FRAC_BITS+1] !== '0)
               report_mismatch("tdata padding", data[RSP_W-1:RATIO_FRAC_BITS+1], 0);
            if (invalid_bit !== want.invalid)
               report_mismatch("union_invalid", invalid_bit, want.invalid);
         end
         result_count++;
      endtask

      task check_drained();
         if (pending != 0)
            report_mismatch("results still missing", 0, pending);
      endtask
   endclass

   //---------------------------------------------------------------------------
   // DUT and signals
   //---------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;

   iou_checker_type chk = new();
   logic            calm = 1'b0;   // no gaps and no stalls while set
   int              cycle_count = 0;

   box_iou_unit #(
      .COORD_BITS      (COORD_BITS),
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #6 clock = ~clock;

   //---------------------------------------------------------------------------
   // Helpers
   //---------------------------------------------------------------------------
   function automatic logic [REQ_W-1:0] boxes(int al, int at, int ar, int ab,
                                              int bl, int bt, int br, int bb);
      return {bb[15:0], br[15:0], bt[15:0], bl[15:0],
              ab[15:0], ar[15:0], at[15:0], al[15:0]};
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 2))
         0:       return $urandom_range(0, 16);
         1:       return $urandom_range(0, 600);
         default: return $urandom_range(0, 30000);
      endcase
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(0, 4))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         3:       return -1;
         default: return 1;
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] random_pair();
      int al, at, w, h, bl, bt, bw, bh, r, tmp;
      r  = $urandom_range(0, 99);
      al = int'($urandom_range(0, 4000)) - 2000;
      at = int'($urandom_range(0, 4000)) - 2000;
      w  = pick_size();
      h  = pick_size();
      bw = pick_size();
      bh = pick_size();
      bl = al + int'($urandom_range(0, w + bw)) - bw;
      bt = at + int'($urandom_range(0, h + bh)) - bh;
      if (r < 55) begin
         // ordinary boxes placed so that they often overlap
         return boxes(al, at, al + w, at + h, bl, bt, bl + bw, bt + bh);
      end else if (r < 65) begin
         // same box or a small jitter of it
         return boxes(al, at, al + w, at + h,
                      al + int'($urandom_range(0, 2)), at + int'($urandom_range(0, 2)),
                      al + w - int'($urandom_range(0, 2)), at + h);
      end else if (r < 80) begin
         return {$urandom, $urandom, $urandom, $urandom};
      end else if (r < 90) begin
         // inverted or flat boxes
         case ($urandom_range(0, 3))
            0: begin tmp = al; al = al + w; w = tmp - al; end
            1: begin tmp = at; at = at + h; h = tmp - at; end
            2: begin tmp = bl; bl = bl + bw; bw = tmp - bl; end
            default: begin w = 0; bh = 0; end
         endcase
         return boxes(al, at, al + w, at + h, bl, bt, bl + bw, bt + bh);
      end else begin
         return boxes(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      end
   endfunction

   // offer one pair, wait for it to be taken; returns at a falling edge
   task automatic send_pair(logic [REQ_W-1:0] pair);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = pair;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      chk.note_request(pair);
      @(negedge clock);
   endtask

   //---------------------------------------------------------------------------
   // Output side: random stalls, one long hold-off to back up the pipeline
   //---------------------------------------------------------------------------
   initial begin
      int stall_left;
      int r;
      logic held;
      stall_left = 0;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held && chk.accepted_count >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (calm) begin
            rsp_tready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               rsp_tready = 1'b1;
            end else begin
               rsp_tready = 1'b0;
               stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 50);
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         chk.check_result(rsp_tdata, rsp_tuser);
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   //---------------------------------------------------------------------------
   // Stimulus
   //---------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: identical, disjoint, touching, partial, contained
      send_pair(boxes(0, 0, 16, 16, 0, 0, 16, 16));
      send_pair(boxes(0, 0, 16, 16, 100, 100, 120, 130));
      send_pair(boxes(0, 0, 16, 16, 16, 0, 32, 16));
      send_pair(boxes(0, 0, 16, 16, 0, 16, 16, 32));
      send_pair(boxes(0, 0, 32, 16, 16, 0, 48, 16));
      send_pair(boxes(-40, -40, 40, 40, -8, -8, 8, 8));
      // rounding tie: 1 / 2^17 is half an output step
      send_pair(boxes(0, 0, 1, 1, 0, 0, 512, 256));
      // flat boxes only: union zero
      send_pair(boxes(5, 5, 5, 30, 7, 7, 40, 7));
      send_pair(boxes(0, 0, 0, 0, 0, 0, 0, 0));
      // inverted box driving the union negative
      send_pair(boxes(0, 0, 10, 10, 0, 0, -20, 10));
      // inverted box with positive union left
      send_pair(boxes(0, 0, 100, 100, 10, 10, 0, 20));
      // box inverted in both axes has a positive area
      send_pair(boxes(50, 50, 0, 0, 0, 0, 10, 10));
      // full-range boxes, near saturation
      send_pair(boxes(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
      send_pair(boxes(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32766));
      send_pair(boxes(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
      send_pair(boxes(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768));
      send_pair(boxes(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
      send_pair(boxes(-1, -1, 0, 0, 0, 0, 1, 1));
      send_pair({REQ_W{1'b1}});
      send_pair({8{16'h8000}});
      send_pair({8{16'h7fff}});
      send_pair({8{16'h5555}});
      send_pair({8{16'haaaa}});

      // random pairs, with one stretch without any idling
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         calm = (n >= 600 && n < 800);
         send_pair(random_pair());
      end
      calm = 1'b0;
      req_tvalid = 1'b0;

      // drain
      while (chk.pending != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      chk.check_drained();
      if (chk.fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
